// File: hdl/gsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the gnomonic projection pipeline.
// No dependencies; every other file imports this package.
package gsp_pkg;

  // Angles are rescaled to 2^35 steps per turn: 3 octant bits over a Q32 residue.
  localparam int unsigned ANG_TURN_BITS = 35;
  localparam logic [32:0] Q32_ONE       = 33'h1_0000_0000;
  localparam logic [31:0] PI_Q30        = 32'd3373259426;
  localparam logic [65:0] Q32_HALF      = 66'd2147483648;
  localparam int unsigned RECIP_SHIFT   = 34;
  localparam int unsigned HORNER_STEPS  = 5;

  // Taylor divisors, innermost first.
  localparam int unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [5] = '{132, 90, 56, 30, 12};

  // floor(2^34 / k): estimate is exact or one low for dividends below 2^33.
  localparam logic [31:0] SIN_RECIP [5] = '{
    32'((64'd1 << 34) / 64'd110), 32'((64'd1 << 34) / 64'd72),
    32'((64'd1 << 34) / 64'd42),  32'((64'd1 << 34) / 64'd20),
    32'((64'd1 << 34) / 64'd6)};
  localparam logic [31:0] COS_RECIP [5] = '{
    32'((64'd1 << 34) / 64'd132), 32'((64'd1 << 34) / 64'd90),
    32'((64'd1 << 34) / 64'd56),  32'((64'd1 << 34) / 64'd30),
    32'((64'd1 << 34) / 64'd12)};

  // Pipeline depths of the fixed-latency units.
  localparam int unsigned SC_LAT   = 21;
  localparam int unsigned COMB_LAT = 5;

  // Q60 magnitudes never reach 2^62; the clamped denominator is above 2^40.
  localparam int unsigned NUM_W        = 62;
  localparam int unsigned DEN_MIN_LOG2 = 40;
  localparam logic signed [63:0] TINY_Q60 = 64'sd1152921504607;
  localparam logic [62:0] COORD_MAX = {63{1'b1}};

  // Configuration port.
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENT_RA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENT_DEC = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CLAMP_POS = 2'd1;
  localparam logic [1:0] ST_CLAMP_NEG = 2'd2;
  localparam logic [1:0] ST_FAR_SIDE  = 2'd3;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } gsp_div_req_t;

  // Q32 product rounded half up.
  function automatic logic [32:0] mul_q32(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b) + Q32_HALF;
    return p[64:32];
  endfunction

  function automatic logic [NUM_W-1:0] mag62(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m[NUM_W-1:0];
  endfunction

endpackage

// File: hdl/gsp_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine: octant fold, Q32 Taylor series in Horner form, Q30 out.
// Depends on gsp_pkg.
module gsp_sincos #(
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ANGLE_WIDTH-1:0]  angle_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);
  import gsp_pkg::*;

  logic [ANG_TURN_BITS-1:0] a_turn;

  generate
    if (ANGLE_WIDTH >= ANG_TURN_BITS) begin : g_down
      assign a_turn = angle_i[ANGLE_WIDTH-1 -: ANG_TURN_BITS];
    end else begin : g_up
      assign a_turn = {angle_i, {(ANG_TURN_BITS - ANGLE_WIDTH){1'b0}}};
    end
  endgenerate

  // Octant fold
  logic [32:0] u_d, u_q;
  logic [2:0]  oct0_q, oct1_q, oct2_q;
  logic [31:0] x1_q, x2_q, z2_q;

  assign u_d = a_turn[32] ? (Q32_ONE - {1'b0, a_turn[31:0]}) : {1'b0, a_turn[31:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u_d;
      oct0_q <= a_turn[34:32];
      x1_q   <= 32'(mul_q32(u_q, {1'b0, PI_Q30}));
      oct1_q <= oct0_q;
      z2_q   <= 32'(mul_q32({1'b0, x1_q}, {1'b0, x1_q}));
      x2_q   <= x1_q;
      oct2_q <= oct1_q;
    end
  end

  logic [32:0] ts_a [HORNER_STEPS+1];
  logic [32:0] tc_a [HORNER_STEPS+1];
  logic [31:0] z_a  [HORNER_STEPS+1];
  logic [31:0] x_a  [HORNER_STEPS+1];
  logic [2:0]  oct_a[HORNER_STEPS+1];

  assign ts_a[0]  = Q32_ONE;
  assign tc_a[0]  = Q32_ONE;
  assign z_a[0]   = z2_q;
  assign x_a[0]   = x2_q;
  assign oct_a[0] = oct2_q;

  // One Horner step per three stages: product, reciprocal estimate, correction.
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    localparam logic [33:0] KS      = 34'(SIN_DIV[i]);
    localparam logic [33:0] KC      = 34'(COS_DIV[i]);
    localparam logic [33:0] KS_HALF = 34'(SIN_DIV[i] / 2);
    localparam logic [33:0] KC_HALF = 34'(COS_DIV[i] / 2);

    logic [32:0] ps_q, pc_q, qs_q, qc_q, ts_q, tc_q;
    logic [33:0] ws_d, wc_d, ws_q, wc_q, rs_rem, rc_rem;
    logic [65:0] rs_prod, rc_prod;
    logic [31:0] za_q, zb_q, zc_q, xa_q, xb_q, xc_q;
    logic [2:0]  oa_q, ob_q, oc_q;

    assign ws_d    = {1'b0, ps_q} + KS_HALF;
    assign wc_d    = {1'b0, pc_q} + KC_HALF;
    assign rs_prod = 66'(ws_d) * 66'(SIN_RECIP[i]);
    assign rc_prod = 66'(wc_d) * 66'(COS_RECIP[i]);
    assign rs_rem  = ws_q - 34'({1'b0, qs_q} * KS);
    assign rc_rem  = wc_q - 34'({1'b0, qc_q} * KC);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ps_q <= mul_q32({1'b0, z_a[i]}, ts_a[i]);
        pc_q <= mul_q32({1'b0, z_a[i]}, tc_a[i]);
        za_q <= z_a[i];
        xa_q <= x_a[i];
        oa_q <= oct_a[i];
        ws_q <= ws_d;
        wc_q <= wc_d;
        qs_q <= 33'(rs_prod >> RECIP_SHIFT);
        qc_q <= 33'(rc_prod >> RECIP_SHIFT);
        zb_q <= za_q;
        xb_q <= xa_q;
        ob_q <= oa_q;
        ts_q <= Q32_ONE - (qs_q + 33'(rs_rem >= KS));
        tc_q <= Q32_ONE - (qc_q + 33'(rc_rem >= KC));
        zc_q <= zb_q;
        xc_q <= xb_q;
        oc_q <= ob_q;
      end
    end

    assign ts_a[i+1]  = ts_q;
    assign tc_a[i+1]  = tc_q;
    assign z_a[i+1]   = zc_q;
    assign x_a[i+1]   = xc_q;
    assign oct_a[i+1] = oc_q;
  end

  // Final products, Q30 rounding and octant symmetry
  logic [32:0] sv_q, cv_q, s2_q, c2_q;
  logic [2:0]  of1_q, of2_q;
  logic [30:0] sq, cq;
  logic signed [31:0] sp, cp, sin_d, cos_d, sin_q, cos_q;

  assign sq = 31'((s2_q + 33'd2) >> 2);
  assign cq = 31'((c2_q + 33'd2) >> 2);
  assign sp = {1'b0, sq};
  assign cp = {1'b0, cq};

  always_comb begin
    case (of2_q)
      3'd0:    begin sin_d = sp;  cos_d = cp;  end
      3'd1:    begin sin_d = cp;  cos_d = sp;  end
      3'd2:    begin sin_d = cp;  cos_d = -sp; end
      3'd3:    begin sin_d = sp;  cos_d = -cp; end
      3'd4:    begin sin_d = -sp; cos_d = -cp; end
      3'd5:    begin sin_d = -cp; cos_d = -sp; end
      3'd6:    begin sin_d = -cp; cos_d = sp;  end
      default: begin sin_d = -sp; cos_d = cp;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q  <= mul_q32({1'b0, x_a[HORNER_STEPS]}, ts_a[HORNER_STEPS]);
      cv_q  <= mul_q32({1'b0, z_a[HORNER_STEPS]}, tc_a[HORNER_STEPS]);
      of1_q <= oct_a[HORNER_STEPS];
      s2_q  <= sv_q;
      c2_q  <= Q32_ONE - ((cv_q + 33'd1) >> 1);
      of2_q <= of1_q;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: hdl/gsp_comb.sv
`timescale 1ns / 1ps
// Forms the Q60 denominator and numerators, classifies the denominator and
// builds the two divider requests. Depends on gsp_pkg.
module gsp_comb (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [31:0]   s0_i,
  input  logic signed [31:0]   c0_i,
  input  logic signed [31:0]   s1_i,
  input  logic signed [31:0]   c1_i,
  input  logic signed [31:0]   sr_i,
  input  logic signed [31:0]   cr_i,
  output gsp_pkg::gsp_div_req_t req_x_o,
  output gsp_pkg::gsp_div_req_t req_y_o,
  output logic [1:0]           status_o
);
  import gsp_pkg::*;

  logic signed [63:0] pcc_q, psc_q;
  logic signed [31:0] s0a_q, c0a_q, s1a_q, c1a_q, sra_q;
  logic signed [31:0] rcc_q, rsc_q, s0b_q, c0b_q, s1b_q, c1b_q, srb_q;
  logic signed [63:0] mss_q, mcr_q, msc_q, mcs_q, mx_q;
  logic signed [63:0] den_q, ny_q, nx_q, dsel;
  logic [1:0]         st_d, st_q;
  gsp_div_req_t       rx_d, ry_d, rx_q, ry_q;

  // Classify the denominator; clamp the near-ninety-degree band.
  always_comb begin
    if (den_q > TINY_Q60) begin
      st_d = ST_OK;
      dsel = den_q;
    end else if (den_q >= 64'sd0) begin
      st_d = ST_CLAMP_POS;
      dsel = TINY_Q60;
    end else if (den_q > -TINY_Q60) begin
      st_d = ST_CLAMP_NEG;
      dsel = -TINY_Q60;
    end else begin
      st_d = ST_FAR_SIDE;
      dsel = den_q;
    end
    rx_d.neg = nx_q[63] ^ dsel[63];
    rx_d.num = mag62(nx_q);
    rx_d.den = mag62(dsel);
    ry_d.neg = ny_q[63] ^ dsel[63];
    ry_d.num = mag62(ny_q);
    ry_d.den = mag62(dsel);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pcc_q <= c0_i * cr_i;
      psc_q <= s0_i * cr_i;
      s0a_q <= s0_i;
      c0a_q <= c0_i;
      s1a_q <= s1_i;
      c1a_q <= c1_i;
      sra_q <= sr_i;
      // inner product back to Q30, half toward plus infinity
      rcc_q <= 32'((pcc_q + 64'sd536870912) >>> 30);
      rsc_q <= 32'((psc_q + 64'sd536870912) >>> 30);
      s0b_q <= s0a_q;
      c0b_q <= c0a_q;
      s1b_q <= s1a_q;
      c1b_q <= c1a_q;
      srb_q <= sra_q;
      mss_q <= s1b_q * s0b_q;
      mcr_q <= c1b_q * rcc_q;
      msc_q <= s1b_q * c0b_q;
      mcs_q <= c1b_q * rsc_q;
      mx_q  <= c1b_q * srb_q;
      den_q <= mss_q + mcr_q;
      ny_q  <= msc_q - mcs_q;
      nx_q  <= mx_q;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      st_q  <= st_d;
    end
  end

  assign req_x_o  = rx_q;
  assign req_y_o  = ry_q;
  assign status_o = st_q;

endmodule

// File: hdl/gsp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, then round-to-nearest
// (ties away from zero), saturation and sign. Depends on gsp_pkg.
module gsp_div #(
  parameter int FRAC_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  gsp_pkg::gsp_div_req_t req_i,
  output logic signed [63:0]    quo_o
);
  import gsp_pkg::*;

  localparam int QW = FRAC_BITS + NUM_W - DEN_MIN_LOG2;
  localparam int RW = NUM_W + QW;
  localparam int EW = (QW + 1 > 64) ? QW + 1 : 64;

  logic [RW-1:0]    aq_a  [QW+1];
  logic [NUM_W-1:0] den_a [QW+1];
  logic             neg_a [QW+1];

  // Top dividend bits already sit below the denominator.
  assign aq_a[0]  = {{(NUM_W - DEN_MIN_LOG2){1'b0}}, req_i.num[NUM_W-1 -: DEN_MIN_LOG2],
                     req_i.num[NUM_W-DEN_MIN_LOG2-1:0], {FRAC_BITS{1'b0}}};
  assign den_a[0] = req_i.den;
  assign neg_a[0] = req_i.neg;

  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic [NUM_W:0]   sh, df;
    logic             ge;
    logic [RW-1:0]    aq_q;
    logic [NUM_W-1:0] den_q;
    logic             neg_q;

    assign sh = {aq_a[k][RW-1:QW], aq_a[k][QW-1]};
    assign df = sh - {1'b0, den_a[k]};
    assign ge = sh >= {1'b0, den_a[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        aq_q  <= {(ge ? df[NUM_W-1:0] : sh[NUM_W-1:0]), aq_a[k][QW-2:0], ge};
        den_q <= den_a[k];
        neg_q <= neg_a[k];
      end
    end

    assign aq_a[k+1]  = aq_q;
    assign den_a[k+1] = den_q;
    assign neg_a[k+1] = neg_q;
  end

  logic [NUM_W-1:0] rem;
  logic [QW-1:0]    quo_raw;
  logic             up;
  logic [QW:0]      qr_q;
  logic             negr_q;
  logic [EW-1:0]    ext;
  logic             sat;
  logic [62:0]      mag;
  logic signed [63:0] quo_q;

  assign rem     = aq_a[QW][RW-1:QW];
  assign quo_raw = aq_a[QW][QW-1:0];
  assign up      = {rem, 1'b0} >= {1'b0, den_a[QW]};
  assign ext     = EW'(qr_q);
  assign sat     = ext > EW'(COORD_MAX);
  assign mag     = sat ? COORD_MAX : ext[62:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qr_q   <= {1'b0, quo_raw} + {{QW{1'b0}}, up};
      negr_q <= neg_a[QW];
      quo_q  <= negr_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign quo_o = quo_q;

endmodule

// File: hdl/gnomonic_sphere_to_plane_top.sv
`timescale 1ns / 1ps
// Forward gnomonic projection: star (ra, dec) to standard coordinates (xi, eta).
// Stages: sine/cosine, products and classification, the bit-per-stage divider, and the
//   output register. Throughput: one beat per cycle while the pipeline is not held.
// The whole pipeline holds only while a result waits in the output register and the
// last stage is full. Reset clears valid bits and sets both tangent registers to zero.
module gnomonic_sphere_to_plane_top #(
  parameter int ANGLE_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ANGLE_WIDTH-1:0]        star_ra_i,
  input  logic signed [ANGLE_WIDTH-1:0] star_dec_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [63:0]            xi_o,
  output logic signed [63:0]            eta_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gsp_pkg::CFG_W-1:0]     cfg_data_i
);
  import gsp_pkg::*;

  localparam int DIV_LAT = COORD_FRAC_BITS + NUM_W - DEN_MIN_LOG2 + 2;
  localparam int LAT     = SC_LAT + COMB_LAT + DIV_LAT;

  // Tangent point registers; the user must write them only while the pipeline is idle; the block does not enforce this.
  logic [CFG_W-1:0] tangent_ra_q, tangent_dec_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tangent_ra_q  <= '0;
      tangent_dec_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TANGENT_RA:  tangent_ra_q  <= cfg_data_i;
        REG_TANGENT_DEC: tangent_dec_q <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Global advance: hold only when the output is full, not taken, and the
  // last stage has a result waiting behind it.
  logic           stage_en;
  logic [LAT-1:0] vld_q;
  logic           out_valid_q;

  assign stage_en   = out_ready_i || !out_valid_q || !vld_q[LAT-1];
  assign in_ready_o = stage_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (stage_en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Three angle units in lockstep: tangent dec, star dec, ra difference.
  logic [ANGLE_WIDTH-1:0] dra;
  logic signed [31:0]     s0, c0, s1, c1, sr, cr;

  assign dra = star_ra_i - ANGLE_WIDTH'(tangent_ra_q);

  gsp_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_tan (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .angle_i (ANGLE_WIDTH'(tangent_dec_q)),
    .sin_o   (s0),
    .cos_o   (c0)
  );

  gsp_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_dec (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .angle_i (star_dec_i),
    .sin_o   (s1),
    .cos_o   (c1)
  );

  gsp_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_dra (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .angle_i (dra),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  gsp_div_req_t req_x, req_y;
  logic [1:0]   comb_status;

  gsp_comb u_comb (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .s0_i     (s0),
    .c0_i     (c0),
    .s1_i     (s1),
    .c1_i     (c1),
    .sr_i     (sr),
    .cr_i     (cr),
    .req_x_o  (req_x),
    .req_y_o  (req_y),
    .status_o (comb_status)
  );

  logic signed [63:0] xi_div, eta_div;

  gsp_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_xi (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .req_i (req_x),
    .quo_o (xi_div)
  );

  gsp_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_eta (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .req_i (req_y),
    .quo_o (eta_div)
  );

  // Carry status alongside the dividers.
  logic [1:0] st_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      st_q[0] <= comb_status;
      for (int k = 1; k < DIV_LAT; k++) begin
        st_q[k] <= st_q[k-1];
      end
    end
  end

  // Output register: frees the pipeline while a result waits.
  logic signed [63:0] xi_q, eta_q;
  logic [1:0]         status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_en && vld_q[LAT-1]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en && vld_q[LAT-1]) begin
      xi_q     <= xi_div;
      eta_q    <= eta_div;
      status_q <= st_q[DIV_LAT-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign xi_o        = xi_q;
  assign eta_o       = eta_q;
  assign status_o    = status_q;

  // Input is refused only behind a full, untaken output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && vld_q[LAT-1]))
    else $error("pipeline stalled without a blocked result");

  // An accepted beat enters the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted beat lost at pipeline entry");

  // A stall freezes every valid bit.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_en |=> (vld_q == $past(vld_q)))
    else $error("valid bits moved during stall");

  // A finished result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && vld_q[LAT-1]) |=> $stable(xi_o) && $stable(eta_o))
    else $error("waiting result overwritten");

endmodule

// File: sim/gnomonic_sphere_to_plane_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for gnomonic_sphere_to_plane_top: bit-exact projection
// predictor, random sender bursts, receiver stalls. Depends on gsp_pkg and the top.
module gnomonic_sphere_to_plane_top_test;
  import gsp_pkg::*;

  // Indexes outside the register map: writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 120;
  localparam longint TINY     = 64'sd1152921504607;

  typedef struct {
    logic signed [63:0] xi;
    logic signed [63:0] eta;
    logic [1:0]         status;
  } coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] star_ra = '0;
  logic signed [31:0] star_dec = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] xi, eta;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Local copy of the tangent point.
  logic [31:0] tan_ra = '0;
  logic [31:0] tan_dec = '0;

  coord_t pending_coords[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int stall_phase = 0;
  int stall_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gnomonic_sphere_to_plane_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .star_ra_i(star_ra), .star_dec_i(star_dec),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .xi_o(xi), .eta_o(eta), .status_o(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd2147483648) >> 32;
  endfunction

  function automatic longint unsigned div_near(longint unsigned v, longint unsigned k);
    return (v + k / 2) / k;
  endfunction

  // Octant-reduced Taylor sine/cosine, results in signed Q30.
  function automatic void sin_cos_q30(input logic [31:0] ang, output longint so,
                                      output longint co);
    logic [34:0] a;
    logic [2:0] oct;
    longint unsigned r, u, x, z, t, sv, cv;
    longint sq, cq;
    int sdiv[5];
    int cdiv[5];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12};
    a = {ang, 3'b000};
    oct = a[34:32];
    r = a[31:0];
    u = oct[0] ? (64'd1 << 32) - r : r;
    x = q32_mul(u, 64'd3373259426);
    z = q32_mul(x, x);
    t = (64'd1 << 32) - div_near(z, sdiv[0]);
    for (int i = 1; i < 5; i++) t = (64'd1 << 32) - div_near(q32_mul(z, t), sdiv[i]);
    sv = q32_mul(x, t);
    t = (64'd1 << 32) - div_near(z, cdiv[0]);
    for (int i = 1; i < 5; i++) t = (64'd1 << 32) - div_near(q32_mul(z, t), cdiv[i]);
    cv = (64'd1 << 32) - div_near(q32_mul(z, t), 2);
    sq = longint'((sv + 2) >> 2);
    cq = longint'((cv + 2) >> 2);
    case (oct)
      3'd0: begin so = sq;  co = cq;  end
      3'd1: begin so = cq;  co = sq;  end
      3'd2: begin so = cq;  co = -sq; end
      3'd3: begin so = sq;  co = -cq; end
      3'd4: begin so = -sq; co = -cq; end
      3'd5: begin so = -cq; co = -sq; end
      3'd6: begin so = -cq; co = sq;  end
      default: begin so = -sq; co = cq; end
    endcase
  endfunction

  // Signed Q60 / Q60 to 40 fraction bits, nearest, ties away from zero.
  function automatic longint plane_div(longint n, longint d);
    longint unsigned lim, an, ad, q, r;
    logic neg, sat;
    lim = 64'h7FFF_FFFF_FFFF_FFFF;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    sat = 1'b0;
    if (ad == 0) ad = 1;
    q = an / ad;
    r = an % ad;
    for (int i = 0; i < 40; i++) begin
      if (q > (lim >> 1)) begin
        sat = 1'b1;
        break;
      end
      q = q << 1;
      r = r << 1;
      if (r >= ad) begin
        r = r - ad;
        q = q | 1;
      end
    end
    if (!sat && (r << 1) >= ad) q++;
    if (sat || q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic coord_t project_star(logic [31:0] ra, logic [31:0] dec);
    longint s0, c0, s1, c1, sr, cr, den, nx, ny;
    coord_t res;
    sin_cos_q30(tan_dec, s0, c0);
    sin_cos_q30(dec, s1, c1);
    sin_cos_q30(ra - tan_ra, sr, cr);
    den = s1 * s0 + c1 * ((c0 * cr + 64'sd536870912) >>> 30);
    nx = c1 * sr;
    ny = s1 * c0 - c1 * ((s0 * cr + 64'sd536870912) >>> 30);
    if (den > TINY) res.status = ST_OK;
    else if (den >= 0) begin
      res.status = ST_CLAMP_POS;
      den = TINY;
    end else if (den > -TINY) begin
      res.status = ST_CLAMP_NEG;
      den = -TINY;
    end else res.status = ST_FAR_SIDE;
    res.xi = plane_div(nx, den);
    res.eta = plane_div(ny, den);
    return res;
  endfunction

  // ---------------------------------------------------------------- monitors
  // Predict on every accepted input beat; compare every accepted output beat.
  always @(posedge clk) begin
    coord_t want;
    if (in_valid && in_ready) pending_coords.push_back(project_star(star_ra, star_dec));
    if (out_valid && out_ready) begin
      if (pending_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat xi=%0d eta=%0d", xi, eta);
      end else begin
        want = pending_coords.pop_front();
        if (want.xi !== xi || want.eta !== eta || want.status !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: xi %0d/%0d eta %0d/%0d status %0d/%0d (expected/actual)",
                     want.xi, xi, want.eta, eta, want.status, status);
        end
      end
    end
  end

  // Count cycles with no beat on any channel; bail out when stuck.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall_mode is redrawn from four patterns as stall_phase advances; one long hold-off on request.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= (stall_phase % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers
  // Send one star; valid stays high across a burst, drops for the gaps.
  task automatic send_star(input logic [31:0] ra, input logic [31:0] dec);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    star_ra <= ra;
    star_dec <= dec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write a register once the pipeline has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coords.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_TANGENT_RA) tan_ra = val;
    else if (idx == REG_TANGENT_DEC) tan_dec = val;
  endtask

  function automatic logic [31:0] rand_dec();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
  endfunction

  // ---------------------------------------------------------------- tests
  // Poles, extremes, on-tangent, right-angle clamps, far side, dec past 90.
  task automatic test_directed();
    send_star(32'h0, 32'h0);
    send_star(32'hFFFF_FFFF, 32'h0);
    send_star(32'h0, 32'h4000_0000);
    send_star(32'h0, 32'hC000_0000);
    send_star(32'h1234_5678, 32'h7FFF_FFFF);
    send_star(32'h8765_4321, 32'h8000_0000);
    send_star(32'h4000_0000, 32'h0);
    send_star(32'hC000_0000, 32'h0);
    send_star(32'h4000_0001, 32'h0);
    send_star(32'hBFFF_FFFF, 32'h0);
    send_star(32'h8000_0000, 32'h0);
    send_star(32'h8000_0000, 32'h2000_0000);
    send_star(32'h0000_0001, 32'hFFFF_FFFF);
    send_star(32'hAAAA_AAAA, 32'h5555_5555);
    send_star(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Random stars, some aimed at the right-angle boundary around the tangent point.
  task automatic test_random(input int count);
    logic [31:0] ra;
    for (int i = 0; i < count; i++) begin
      ra = $urandom();
      if ($urandom_range(0, 7) == 0)
        ra = tan_ra + ($urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000)
             + $urandom_range(0, 8) - 4;
      send_star(ra, ($urandom_range(0, 7) == 0) ? 32'h0 : rand_dec());
    end
  endtask

  // Hold the receiver off long enough to back the pipeline up into the input.
  task automatic test_backpressure();
    hold_go <= 1'b1;
    while (!hold_done) @(posedge clk);
    burst_left = 400;
    test_random(250);
  endtask

  task automatic test_config_sweep();
    write_reg(REG_TANGENT_RA, 32'hFFFF_FFFF);
    write_reg(REG_TANGENT_DEC, 32'h4000_0000);
    test_directed();
    test_random(200);
    write_reg(REG_TANGENT_RA, $urandom());
    write_reg(REG_TANGENT_DEC, 32'hC000_0000);
    test_random(200);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    write_reg(REG_TANGENT_RA, $urandom());
    write_reg(REG_TANGENT_DEC, rand_dec());
    test_random(300);
    write_reg(REG_TANGENT_RA, 32'h0);
    write_reg(REG_TANGENT_DEC, 32'h0);
    test_random(150);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_config_sweep();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_coords.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
